// File: rtl/cpf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the class 1 input frame parser.
// No dependencies; used by every module under rtl.
package cpf_pkg;

    // Status codes reported with the frame end
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TRUNC      = 3'd1;
    localparam logic [2:0] ST_SHORT_ADDR = 3'd2;
    localparam logic [2:0] ST_SHORT_DATA = 3'd3;
    localparam logic [2:0] ST_NO_ADDR    = 3'd4;
    localparam logic [2:0] ST_NO_DATA    = 3'd5;

    // Item body layout
    localparam logic [15:0] ID_BYTES       = 16'd4;
    localparam logic [15:0] DATA_HDR_SHORT = 16'd2;
    localparam logic [15:0] DATA_HDR_LONG  = 16'd6;

    // Configuration reset values
    localparam logic [15:0] ADDR_TYPE_RESET = 16'h8002;
    localparam logic [15:0] DATA_TYPE_RESET = 16'h00B1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        payload_first;
        logic        done_res;
        logic [2:0]  status;
        logic [31:0] conn_id;
        logic [15:0] payload_length;
    } t_out_item;

    typedef struct packed {
        logic [15:0] address_item_type;
        logic [15:0] data_item_type;
        logic        skip_ri;
    } t_cfg;

endpackage

// File: rtl/cpf_parser_core.sv
`timescale 1ns / 1ps
// Frame parser state and its single-pass next-state logic.
// Depends on cpf_pkg for item, configuration and status types.
module cpf_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpf_pkg::t_cfg       i_cfg,
    input  logic                i_accept,
    input  cpf_pkg::t_in_item   i_item,
    output logic                o_push,
    output cpf_pkg::t_out_item  o_result
);

    localparam logic [2:0] PH_COUNT    = 3'd0;
    localparam logic [2:0] PH_HEADER   = 3'd1;
    localparam logic [2:0] PH_BODY     = 3'd2;
    localparam logic [2:0] PH_FINISHED = 3'd3;
    localparam logic [2:0] PH_ERROR    = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_hdr_idx, n_hdr_idx;
    logic [15:0] r_items_left, n_items_left;
    logic [15:0] r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [15:0] r_pos, n_pos;
    logic [31:0] r_id, n_id;
    logic        r_seen_addr, n_seen_addr;
    logic        r_seen_data, n_seen_data;
    logic [2:0]  r_error, n_error;
    logic [15:0] r_last_len, n_last_len;

    logic [15:0] hdr_len;
    logic        item_end;
    logic        pv;
    logic        pf;
    logic [2:0]  st;

    assign hdr_len = i_cfg.skip_ri ? cpf_pkg::DATA_HDR_LONG : cpf_pkg::DATA_HDR_SHORT;

    // Work out the next state and the result for the item on the input
    always_comb begin
        n_phase      = r_phase;
        n_hdr_idx    = r_hdr_idx;
        n_items_left = r_items_left;
        n_type       = r_type;
        n_len        = r_len;
        n_pos        = r_pos;
        n_id         = r_id;
        n_seen_addr  = r_seen_addr;
        n_seen_data  = r_seen_data;
        n_error      = r_error;
        n_last_len   = r_last_len;
        item_end     = 1'b0;
        pv           = 1'b0;
        pf           = 1'b0;
        st           = cpf_pkg::ST_OK;

        case (r_phase)
            PH_COUNT: begin
                if (r_hdr_idx == 2'd0) begin
                    n_items_left = {8'd0, i_item.in_byte};
                    n_hdr_idx    = 2'd1;
                end else begin
                    n_items_left = {i_item.in_byte, r_items_left[7:0]};
                    n_hdr_idx    = 2'd0;
                    n_phase      = (n_items_left == 16'd0) ? PH_FINISHED : PH_HEADER;
                end
            end
            PH_HEADER: begin
                case (r_hdr_idx)
                    2'd0:    n_type = {8'd0, i_item.in_byte};
                    2'd1:    n_type = {i_item.in_byte, r_type[7:0]};
                    2'd2:    n_len  = {8'd0, i_item.in_byte};
                    default: n_len  = {i_item.in_byte, r_len[7:0]};
                endcase
                if (r_hdr_idx == 2'd3) begin
                    // Header complete: check the item against its minimum length
                    n_hdr_idx = 2'd0;
                    n_pos     = 16'd0;
                    if (n_type == i_cfg.address_item_type) begin
                        if (n_len < cpf_pkg::ID_BYTES) begin
                            n_error = cpf_pkg::ST_SHORT_ADDR;
                        end else begin
                            n_seen_addr = 1'b1;
                        end
                    end else if (n_type == i_cfg.data_item_type) begin
                        if (n_len < hdr_len) begin
                            n_error = cpf_pkg::ST_SHORT_DATA;
                        end else begin
                            n_seen_data = 1'b1;
                            n_last_len  = n_len - hdr_len;
                        end
                    end
                    if (n_len == 16'd0) begin
                        item_end = 1'b1;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end else begin
                    n_hdr_idx = r_hdr_idx + 2'd1;
                end
            end
            PH_BODY: begin
                if (r_error == cpf_pkg::ST_OK) begin
                    if (r_type == i_cfg.address_item_type) begin
                        if (r_pos < cpf_pkg::ID_BYTES) begin
                            n_id[{r_pos[1:0], 3'b000} +: 8] = i_item.in_byte;
                        end
                    end else if (r_type == i_cfg.data_item_type) begin
                        if (r_pos >= hdr_len) begin
                            pv = 1'b1;
                            pf = (r_pos == hdr_len);
                        end
                    end
                end
                n_pos = r_pos + 16'd1;
                if (n_pos >= r_len) begin
                    item_end = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Close the item: drop into the error phase or move to the next item
        if (item_end) begin
            if (n_error != cpf_pkg::ST_OK) begin
                n_phase = PH_ERROR;
            end else begin
                n_items_left = r_items_left - 16'd1;
                n_phase      = (n_items_left == 16'd0) ? PH_FINISHED : PH_HEADER;
                n_hdr_idx    = 2'd0;
            end
        end

        // Frame status, by priority
        if (n_error != cpf_pkg::ST_OK) begin
            st = n_error;
        end else if (n_phase != PH_FINISHED) begin
            st = cpf_pkg::ST_TRUNC;
        end else if (!n_seen_addr) begin
            st = cpf_pkg::ST_NO_ADDR;
        end else if (!n_seen_data) begin
            st = cpf_pkg::ST_NO_DATA;
        end

        o_result.payload_valid  = pv;
        o_result.payload_byte   = pv ? i_item.in_byte : 8'd0;
        o_result.payload_first  = pf;
        o_result.done_res       = i_item.frame_end;
        o_result.status         = i_item.frame_end ? st : cpf_pkg::ST_OK;
        o_result.conn_id        = i_item.frame_end ? n_id : 32'd0;
        o_result.payload_length = i_item.frame_end ? n_last_len : 16'd0;

        // Rearm for the next frame
        if (i_item.frame_end) begin
            n_phase      = PH_COUNT;
            n_hdr_idx    = 2'd0;
            n_items_left = 16'd0;
            n_type       = 16'd0;
            n_len        = 16'd0;
            n_pos        = 16'd0;
            n_id         = 32'd0;
            n_seen_addr  = 1'b0;
            n_seen_data  = 1'b0;
            n_error      = cpf_pkg::ST_OK;
            n_last_len   = 16'd0;
        end
    end

    assign o_push = i_accept && (pv || i_item.frame_end);

    // Advance the state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_COUNT;
            r_hdr_idx    <= 2'd0;
            r_items_left <= 16'd0;
            r_type       <= 16'd0;
            r_len        <= 16'd0;
            r_pos        <= 16'd0;
            r_id         <= 32'd0;
            r_seen_addr  <= 1'b0;
            r_seen_data  <= 1'b0;
            r_error      <= cpf_pkg::ST_OK;
            r_last_len   <= 16'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_hdr_idx    <= n_hdr_idx;
            r_items_left <= n_items_left;
            r_type       <= n_type;
            r_len        <= n_len;
            r_pos        <= n_pos;
            r_id         <= n_id;
            r_seen_addr  <= n_seen_addr;
            r_seen_data  <= n_seen_data;
            r_error      <= n_error;
            r_last_len   <= n_last_len;
        end
    end

    // A frame end leaves the parser rearmed
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.frame_end) |=>
            (r_phase == PH_COUNT && r_error == cpf_pkg::ST_OK && !r_seen_addr))
        else $error("parser not rearmed after frame end");

    // A latched error only lives in the body or error phase
    a_error_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error != cpf_pkg::ST_OK) |-> (r_phase == PH_BODY || r_phase == PH_ERROR))
        else $error("error code outside body or error phase");

    // The first payload marker comes only with a payload byte
    a_first_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.payload_first) |-> o_result.payload_valid)
        else $error("payload_first without payload_valid");

endmodule

// File: rtl/cpf_out_fifo.sv
`timescale 1ns / 1ps
// Two-entry result queue between the parser and the output channel.
// Depends on cpf_pkg for the result item type.
module cpf_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cpf_pkg::t_out_item  i_data,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_ready,
    output cpf_pkg::t_out_item  o_data
);

    cpf_pkg::t_out_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("result pushed into a full queue");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("fill level did not follow a push");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("fill level beyond two entries");

endmodule

// File: rtl/cpf_class1_input_frame_parser_top.sv
`timescale 1ns / 1ps
// Top level of the class 1 input frame parser: configuration registers,
// parser core and result queue. Depends on cpf_pkg, cpf_parser_core, cpf_out_fifo.
//
//  Channel   Direction  Handshake               Payload
//  in        input      i_in_valid/o_in_ready   i_in_data   (t_in_item)
//  out       output     o_out_valid/i_out_ready o_out_data  (t_out_item)
//  cfg       input      i_cfg_we                i_cfg_index, i_cfg_wdata
//
// One frame byte is taken every cycle while o_in_ready is high; each byte is
// parsed in the cycle it is accepted and its result, if any, is written into a
// two-entry queue at that edge and offered on out from the next cycle.
// o_in_ready drops only while both queue entries hold results waiting on out.
// Reset is synchronous, active low, and clears parser state, queue and
// configuration to their defaults; no clearing pass is needed.
module cpf_class1_input_frame_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cpf_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cpf_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wdata
);

    localparam logic [1:0] CFG_ADDR_TYPE = 2'd0;
    localparam logic [1:0] CFG_DATA_TYPE = 2'd1;
    localparam logic [1:0] CFG_SKIP_RI   = 2'd2;

    cpf_pkg::t_cfg      r_cfg;
    cpf_pkg::t_out_item result;
    logic               accept;
    logic               push;
    logic               full;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_item_type <= cpf_pkg::ADDR_TYPE_RESET;
            r_cfg.data_item_type    <= cpf_pkg::DATA_TYPE_RESET;
            r_cfg.skip_ri           <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ADDR_TYPE: r_cfg.address_item_type <= i_cfg_wdata;
                CFG_DATA_TYPE: r_cfg.data_item_type    <= i_cfg_wdata;
                CFG_SKIP_RI:   r_cfg.skip_ri           <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    cpf_parser_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_result (result)
    );

    cpf_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
